/* hdl/hdlf_pkg.sv */
// Package for the hex dump line formatter.
// Holds the channel payload types, the emitter phase type and the character helpers.
// No dependencies.
package hdlf_pkg;

  // One input transaction: a data byte or an end-of-stream marker.
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_t;

  // One output transaction: one character of a dump line.
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_line;
  } out_t;

  // Input kinds.
  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // Phases of the line emitter, in the order they appear on a line.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OFF,
    PH_SP,
    PH_HEX,
    PH_GAP,
    PH_ASC,
    PH_NL
  } phase_e;

  // Characters used in a dump line.
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] PrintLo   = 8'd32;
  localparam logic [7:0] PrintHi   = 8'd126;

  // Uppercase hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    case (nib)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'hA: c = 8'h41;
      4'hB: c = 8'h42;
      4'hC: c = 8'h43;
      4'hD: c = 8'h44;
      4'hE: c = 8'h45;
      4'hF: c = 8'h46;
      default: c = 8'h30;
    endcase
    return c;
  endfunction

  // Printable bytes show as themselves, all others as a dot.
  function automatic logic [7:0] show_char(input logic [7:0] b);
    logic [7:0] c;
    if (b < PrintLo || b > PrintHi) begin
      c = CharDot;
    end else begin
      c = b;
    end
    return c;
  endfunction

endpackage

/* hdl/hex_dump_line_formatter_core.sv */
// Hex dump line formatter: bytes in, one dump line of text out per BYTES_PER_LINE bytes.
// Instantiates hdlf_front, hdlf_fifo and hdlf_emit. Uses hdlf_pkg.
//
// The block takes one input transaction per cycle while its two-entry line queue has room,
// and emits one character per cycle while the output is not stalled. A full line has
// 8 + 4*BYTES_PER_LINE characters (40 for eight bytes), so over a long stream the
// one-character-per-cycle emitter sets the sustained input rate. A flushed line of k bytes
// has 8 + 3*BYTES_PER_LINE + k characters; an end of stream with no pending bytes emits
// nothing. The emitter goes from the newline of one line straight to the offset digits of
// the next queued line; when it is idle, a completing byte passes through the line queue,
// the emitter phase state and the output register before its line's first character shows.
module hex_dump_line_formatter_core #(
  parameter int BYTES_PER_LINE = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hdlf_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hdlf_pkg::out_t out_o
);

  localparam int N     = BYTES_PER_LINE;
  localparam int CntW  = $clog2(N + 1);
  localparam int IdxW  = (N > 1) ? $clog2(N) : 1;
  localparam int DescW = 16 + 8 * N + CntW;

  logic              push_valid, push_ready;
  logic [15:0]       push_off;
  logic [N-1:0][7:0] push_bytes;
  logic [CntW-1:0]   push_cnt;
  logic              desc_valid, desc_ready;
  logic [DescW-1:0]  desc;

  hdlf_front #(
    .N    (N),
    .CntW (CntW),
    .IdxW (IdxW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_off_o   (push_off),
    .push_bytes_o (push_bytes),
    .push_cnt_o   (push_cnt)
  );

  // Line queue carries offset, bytes and byte count of each line.
  hdlf_fifo #(
    .W (DescW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_off, push_bytes, push_cnt}),
    .pop_valid_o  (desc_valid),
    .pop_ready_i  (desc_ready),
    .pop_data_o   (desc)
  );

  hdlf_emit #(
    .N    (N),
    .CntW (CntW),
    .IdxW (IdxW)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_ready_o (desc_ready),
    .desc_off_i   (desc[DescW-1 -: 16]),
    .desc_bytes_i (desc[CntW +: 8 * N]),
    .desc_cnt_i   (desc[CntW-1:0]),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_o)
  );

endmodule

/* hdl/hdlf_front.sv */
// Front end of the hex dump formatter: collects bytes into the line buffer.
// Hands finished or flushed lines to the line queue. Uses hdlf_pkg.
module hdlf_front #(
  parameter int N    = 8,
  parameter int CntW = 4,
  parameter int IdxW = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hdlf_pkg::in_t         in_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output logic [15:0]           push_off_o,
  output logic [N-1:0][7:0]     push_bytes_o,
  output logic [CntW-1:0]       push_cnt_o
);

  logic [15:0]         offset_q, offset_d;
  logic [CntW-1:0]     fill_q, fill_d;
  logic [N-1:0][7:0]   bytes_q;
  logic                is_data;
  logic                line_full;
  logic                accept;

  // An input is taken only while the line queue has room.
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_data    = (in_i.kind == hdlf_pkg::KindData);
  assign line_full  = (fill_q == CntW'(N - 1));

  // Line handed to the queue: the buffer with the new byte merged in.
  always_comb begin
    push_bytes_o = bytes_q;
    if (is_data) begin
      push_bytes_o[fill_q[IdxW-1:0]] = in_i.data_byte;
    end
    push_off_o   = offset_q;
    push_cnt_o   = is_data ? CntW'(N) : fill_q;
    push_valid_o = in_valid_i && (is_data ? line_full : (fill_q != '0));
  end

  // Offset and fill count updates.
  always_comb begin
    offset_d = offset_q;
    fill_d   = fill_q;
    if (accept) begin
      if (!is_data) begin
        offset_d = '0;
        fill_d   = '0;
      end else if (line_full) begin
        offset_d = offset_q + 16'(N);
        fill_d   = '0;
      end else begin
        fill_d = fill_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      fill_q   <= '0;
    end else begin
      offset_q <= offset_d;
      fill_q   <= fill_d;
    end
  end

  // Line buffer payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept && is_data) begin
      bytes_q[fill_q[IdxW-1:0]] <= in_i.data_byte;
    end
  end

endmodule

/* hdl/hdlf_fifo.sv */
// Two-entry line queue between the front end and the emitter.
// Generic over the entry width. No package dependencies.
module hdlf_fifo #(
  parameter int W = 96
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  localparam int Depth = 2;

  logic [Depth-1:0][W-1:0] mem_q;
  logic                    wr_ptr_q, rd_ptr_q;
  logic [1:0]              cnt_q;
  logic                    do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'(Depth));
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/hdlf_emit.sv */
// Back end of the hex dump formatter: walks one queued line and emits a character per cycle
// while the output is not stalled. Ends in an output register. Uses hdlf_pkg.
module hdlf_emit #(
  parameter int N    = 8,
  parameter int CntW = 4,
  parameter int IdxW = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              desc_valid_i,
  output logic              desc_ready_o,
  input  logic [15:0]       desc_off_i,
  input  logic [N-1:0][7:0] desc_bytes_i,
  input  logic [CntW-1:0]   desc_cnt_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hdlf_pkg::out_t    out_o
);

  localparam int XW   = (IdxW > 2) ? IdxW : 2;
  localparam int CmpW = 6;

  hdlf_pkg::phase_e  state_q, state_d;
  logic [XW-1:0]     idx_q, idx_d;
  logic [1:0]        sub_q, sub_d;
  logic [15:0]       cur_off_q;
  logic [N-1:0][7:0] cur_bytes_q;
  logic [CntW-1:0]   cur_cnt_q;
  logic              out_valid_q;
  hdlf_pkg::out_t    out_q;
  logic              adv;
  logic              pop;
  logic [7:0]        ch;
  logic              last;
  logic [7:0]        cur_byte;
  logic [3:0]        off_nib;
  logic              in_line;

  // The output register can take a new character when empty or being drained.
  assign adv          = !out_valid_q || out_ready_i;
  assign desc_ready_o = pop;
  assign out_valid_o  = out_valid_q;
  assign out_o        = out_q;

  assign cur_byte = cur_bytes_q[idx_q[IdxW-1:0]];
  assign off_nib  = 4'(cur_off_q >> {~idx_q[1:0], 2'b00});
  assign in_line  = (CmpW'(idx_q) < CmpW'(cur_cnt_q));

  // Phase sequencing and character selection.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    sub_d   = sub_q;
    ch      = hdlf_pkg::CharSpace;
    last    = 1'b0;
    pop     = 1'b0;
    case (state_q)
      hdlf_pkg::PH_IDLE: begin
        pop = desc_valid_i;
      end
      hdlf_pkg::PH_OFF: begin
        ch = hdlf_pkg::hex_char(off_nib);
        if (adv) begin
          if (idx_q[1:0] == 2'd3) begin
            state_d = hdlf_pkg::PH_SP;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + XW'(1);
          end
        end
      end
      hdlf_pkg::PH_SP: begin
        if (adv) begin
          if (idx_q[1:0] == 2'd1) begin
            state_d = hdlf_pkg::PH_HEX;
            idx_d   = '0;
            sub_d   = 2'd0;
          end else begin
            idx_d = idx_q + XW'(1);
          end
        end
      end
      hdlf_pkg::PH_HEX: begin
        if (in_line && sub_q == 2'd0) begin
          ch = hdlf_pkg::hex_char(cur_byte[7:4]);
        end else if (in_line && sub_q == 2'd1) begin
          ch = hdlf_pkg::hex_char(cur_byte[3:0]);
        end
        if (adv) begin
          if (sub_q == 2'd2) begin
            sub_d = 2'd0;
            if (idx_q == XW'(N - 1)) begin
              state_d = hdlf_pkg::PH_GAP;
              idx_d   = '0;
            end else begin
              idx_d = idx_q + XW'(1);
            end
          end else begin
            sub_d = sub_q + 2'd1;
          end
        end
      end
      hdlf_pkg::PH_GAP: begin
        if (adv) begin
          state_d = hdlf_pkg::PH_ASC;
          idx_d   = '0;
        end
      end
      hdlf_pkg::PH_ASC: begin
        ch = hdlf_pkg::show_char(cur_byte);
        if (adv) begin
          if (CmpW'(idx_q) == CmpW'(cur_cnt_q) - CmpW'(1)) begin
            state_d = hdlf_pkg::PH_NL;
          end else begin
            idx_d = idx_q + XW'(1);
          end
        end
      end
      hdlf_pkg::PH_NL: begin
        ch   = hdlf_pkg::CharLf;
        last = 1'b1;
        if (adv) begin
          if (desc_valid_i) begin
            pop = 1'b1;
          end else begin
            state_d = hdlf_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        state_d = hdlf_pkg::PH_IDLE;
      end
    endcase
    // A newly taken line always starts with the offset digits.
    if (pop) begin
      state_d = hdlf_pkg::PH_OFF;
      idx_d   = '0;
      sub_d   = 2'd0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hdlf_pkg::PH_IDLE;
      idx_q       <= '0;
      sub_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sub_q   <= sub_d;
      if (adv) begin
        out_valid_q <= (state_q != hdlf_pkg::PH_IDLE);
      end
    end
  end

  // Current line and output payload.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_off_q   <= desc_off_i;
      cur_bytes_q <= desc_bytes_i;
      cur_cnt_q   <= desc_cnt_i;
    end
    if (adv) begin
      out_q.out_char     <= ch;
      out_q.last_of_line <= last;
    end
  end

endmodule

/* hdl/hdlf_checker.sv */
// Port-level checks for the hex dump formatter, bound to the top level.
// Depends on hdlf_pkg and hex_dump_line_formatter_core.
module hdlf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input hdlf_pkg::in_t  in_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input hdlf_pkg::out_t out_o
);

  logic out_acc;
  logic line_start_q;

  assign out_acc = out_valid_o && out_ready_i;

  // Tracks whether the next output transaction opens a new line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_start_q <= 1'b1;
    end else if (out_acc) begin
      line_start_q <= out_o.last_of_line;
    end
  end

  // A stalled output transaction holds its character.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("output transaction changed while stalled");

  // The line end marker goes with the newline and only with it.
  a_last_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.last_of_line == (out_o.out_char == hdlf_pkg::CharLf)))
    else $error("line end flag does not match newline character");

  // Every character is printable or a newline.
  a_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_o.out_char >= hdlf_pkg::PrintLo &&
                      out_o.out_char <= hdlf_pkg::PrintHi) ||
                     out_o.out_char == hdlf_pkg::CharLf))
    else $error("unprintable character emitted");

  // Each line opens with an uppercase hex digit of the offset.
  a_line_start_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_start_q |->
      ((out_o.out_char >= 8'h30 && out_o.out_char <= 8'h39) ||
       (out_o.out_char >= 8'h41 && out_o.out_char <= 8'h46)))
    else $error("line does not start with an offset digit");

  // Input side is observed for completeness of the port view.
  a_in_no_x_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !$isunknown(in_i.kind))
    else $error("accepted input transaction has unknown kind");

endmodule

bind hex_dump_line_formatter_core hdlf_checker u_hdlf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

/* tb/hex_dump_line_formatter_core_test.sv */
// Testbench for hex_dump_line_formatter_core: streams bytes and end-of-stream markers in
// and checks every emitted dump character against a line predictor in a small scoreboard.
// Depends on hdlf_pkg and the RTL of hex_dump_line_formatter_core.
`timescale 1ns / 1ps

module hex_dump_line_formatter_core_test;

  localparam int LineBytes   = 8;
  localparam int MaxGap      = 6;
  localparam int RandomItems = 196;
  localparam int DrainCycles = 20;
  localparam int MaxShown    = 10;

  localparam logic [7:0] Digit0  = "0";
  localparam logic [7:0] LetterA = "A";

  // Predicts the dump text and checks the character stream against it.
  class dump_scoreboard;
    hdlf_pkg::out_t chars_q[$];
    logic [15:0]    offset;
    logic [7:0]     held[LineBytes];
    int unsigned    fill;
    int unsigned    failures;

    function new();
      offset   = '0;
      fill     = 0;
      failures = 0;
    endfunction

    function logic [7:0] hex_digit(logic [3:0] nib);
      if (nib < 4'd10) begin
        return Digit0 + 8'(nib);
      end
      return LetterA + 8'(nib - 4'd10);
    endfunction

    function void add_char(logic [7:0] c, logic last);
      hdlf_pkg::out_t e;
      e.out_char     = c;
      e.last_of_line = last;
      chars_q.push_back(e);
    endfunction

    // Builds one line from the first count held bytes at the current offset.
    function void add_line(int unsigned count);
      logic [7:0] b;
      for (int i = 0; i < 4; i++) begin
        add_char(hex_digit(offset[15 - 4 * i -: 4]), 1'b0);
      end
      add_char(hdlf_pkg::CharSpace, 1'b0);
      add_char(hdlf_pkg::CharSpace, 1'b0);
      for (int i = 0; i < LineBytes; i++) begin
        if (i < count) begin
          add_char(hex_digit(held[i][7:4]), 1'b0);
          add_char(hex_digit(held[i][3:0]), 1'b0);
        end else begin
          add_char(hdlf_pkg::CharSpace, 1'b0);
          add_char(hdlf_pkg::CharSpace, 1'b0);
        end
        add_char(hdlf_pkg::CharSpace, 1'b0);
      end
      add_char(hdlf_pkg::CharSpace, 1'b0);
      for (int i = 0; i < count; i++) begin
        b = held[i];
        add_char((b < hdlf_pkg::PrintLo || b > hdlf_pkg::PrintHi) ? hdlf_pkg::CharDot : b,
                 1'b0);
      end
      add_char(hdlf_pkg::CharLf, 1'b1);
    endfunction

    // Notes one accepted input transaction and queues the characters it causes.
    function void note_input(hdlf_pkg::in_t item);
      if (item.kind == hdlf_pkg::KindData) begin
        held[fill] = item.data_byte;
        fill++;
        if (fill == LineBytes) begin
          add_line(LineBytes);
          offset = offset + 16'(LineBytes);
          fill   = 0;
        end
      end else begin
        // End of stream flushes a partial line, then the offset starts over.
        if (fill != 0) begin
          add_line(fill);
        end
        offset = '0;
        fill   = 0;
      end
    endfunction

    // Checks one accepted output transaction against the oldest expected character.
    function void check_char(hdlf_pkg::out_t got);
      hdlf_pkg::out_t want;
      if (chars_q.size() == 0) begin
        if (failures < MaxShown) begin
          $display("unexpected character %h last %b at %0t",
                   got.out_char, got.last_of_line, $realtime);
        end
        failures++;
      end else begin
        want = chars_q.pop_front();
        if (got.out_char !== want.out_char || got.last_of_line !== want.last_of_line) begin
          if (failures < MaxShown) begin
            $display("character mismatch at %0t: expected %h last %b, got %h last %b",
                     $realtime, want.out_char, want.last_of_line,
                     got.out_char, got.last_of_line);
          end
          failures++;
        end
      end
    endfunction

    function int unsigned pending();
      return chars_q.size();
    endfunction

    function void check_drained();
      if (chars_q.size() != 0) begin
        if (failures < MaxShown) begin
          $display("%0d expected characters never arrived", chars_q.size());
        end
        failures++;
      end
    endfunction
  endclass

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  hdlf_pkg::in_t  in_i        = '0;
  logic           out_ready_i = 1'b0;
  logic           in_ready_o;
  logic           out_valid_o;
  hdlf_pkg::out_t out_o;

  bit idle_on = 1'b1;
  dump_scoreboard board = new();

  hex_dump_line_formatter_core #(
    .BYTES_PER_LINE(LineBytes)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int draw_gap();
    return idle_on ? int'($urandom_range(0, MaxGap)) : 0;
  endfunction

  // Byte values weighted toward the printable boundaries.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: return 8'($urandom_range(32, 126));
      2: begin
        case ($urandom_range(0, 3))
          0: return 8'd31;
          1: return 8'd32;
          2: return 8'd126;
          default: return 8'd127;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          return 8'($urandom_range(0, 31));
        end
        return 8'($urandom_range(128, 255));
      end
    endcase
  endfunction

  // Drives one input transaction after a random gap and notes it once accepted.
  task automatic send_item(input logic kind, input logic [7:0] data);
    hdlf_pkg::in_t item;
    int            gap;
    item.kind      = kind;
    item.data_byte = data;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_i       = item;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input(item);
  endtask

  task automatic send_data(input logic [7:0] data);
    send_item(hdlf_pkg::KindData, data);
  endtask

  task automatic send_end(input logic [7:0] data);
    send_item(hdlf_pkg::KindEnd, data);
  endtask

  // Holds the input off until every expected character has come out.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Output side: random stall before each transaction, then check it.
  initial begin : char_sink
    int stall;
    wait (rst_ni);
    forever begin
      stall = draw_gap();
      repeat (stall) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
      end
      @(negedge clk_i);
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      board.check_char(out_o);
    end
  end

  // Stimulus: directed lines, then a random stream with flushes and drains.
  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // End of stream on an empty buffer emits nothing.
    send_end(8'hFF);
    // Full line with both extremes and the printable boundaries.
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'h1F);
    send_data(8'h20);
    send_data(8'h7E);
    send_data(8'h7F);
    send_data(8'h80);
    send_data(8'h5A);
    // Short partial line; the byte on the end marker is ignored.
    send_data(8'h31);
    send_data(8'h32);
    send_data(8'h33);
    send_end(8'hA5);
    // Longest partial line.
    for (int i = 0; i < LineBytes - 1; i++) begin
      send_data(8'h41 + 8'(i));
    end
    send_end(8'h00);
    // One-byte line, then a second end in a row.
    send_data(8'h0A);
    send_end(8'h5A);
    send_end(8'hC3);

    // Random stream with occasional flushes and idle-free stretches.
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 30 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if (i == RandomItems / 2 || $urandom_range(0, 39) == 0) begin
        wait_drained();
      end
      if ($urandom_range(0, 11) == 0) begin
        send_end(8'($urandom_range(0, 255)));
      end else begin
        send_data(pick_byte());
      end
    end

    // Flush whatever partial line is left.
    send_end(8'($urandom_range(0, 255)));
    idle_on = 1'b1;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    board.check_drained();
    if (board.failures == 0) begin
      $display("hex_dump_line_formatter_core_test: done, clean");
    end else begin
      $display("hex_dump_line_formatter_core_test: done, errors");
    end
    $finish;
  end

  // Timeout well beyond the slowest correct run.
  initial begin : watchdog
    #40_000_000;
    $display("hex_dump_line_formatter_core_test: done, errors");
    $finish;
  end

endmodule
